// ----- src/xml_entity_unescape_defines.svh -----
// ---------------------------------------------------------------------------
// xml_entity_unescape_defines
// assertion macros for the checker file xeu_checker
// ---------------------------------------------------------------------------
`ifndef XML_ENTITY_UNESCAPE_DEFINES_SVH
`define XML_ENTITY_UNESCAPE_DEFINES_SVH

// same-cycle implication
`define XEU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define XEU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/xeu_pkg.sv -----
// ---------------------------------------------------------------------------
// xeu_pkg
// shared types, character codes, entity name tables and the utf-8 encoder
// ---------------------------------------------------------------------------
package xeu_pkg;

   localparam int XEU_VALUE_BITS  = 32;
   localparam int XEU_MAX_RESULTS = 6;
   localparam int XEU_COUNT_BITS  = $clog2(XEU_MAX_RESULTS + 1);
   localparam int XEU_NAME_COUNT  = 5;
   localparam int XEU_NAME_CHARS  = 5;
   localparam int XEU_PREFIX_MAX  = 4;

   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;

   // entity names after the ampersand: lt; gt; amp; apos; quot;
   localparam logic [7:0] NAME_TEXT [XEU_NAME_COUNT][XEU_NAME_CHARS] = '{
      '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
      '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
      '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
      '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
      '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}
   };
   localparam logic [2:0] NAME_LEN [XEU_NAME_COUNT] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
   localparam logic [7:0] NAME_CHAR [XEU_NAME_COUNT] = '{8'h3C, 8'h3E, 8'h26, 8'h27, 8'h22};

   typedef enum logic [2:0] {
      MODE_PLAIN,
      MODE_AMP,
      MODE_NUM_START,
      MODE_NUM_DIGITS,
      MODE_STOP
   } mode_type;

   // group of results caused by one item
   typedef struct packed {
      logic [XEU_COUNT_BITS-1:0]        count;
      logic [XEU_MAX_RESULTS-1:0][7:0]  bytes;
      logic                             has_byte;
      logic                             eot;
   } burst_type;

   typedef struct packed {
      logic [XEU_COUNT_BITS-1:0]        count;
      logic [XEU_MAX_RESULTS-1:0][7:0]  bytes;
   } utf8_type;

   // bit 4 set for a byte that is no digit
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         return {1'b0, d[3:0]};
      end
      if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
         return {1'b0, d[3:0]};
      end
      if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
         return {1'b0, d[3:0]};
      end
      return 5'h10;
   endfunction

   // original utf-8, up to six bytes, nothing for codes of 2^31 and above
   function automatic utf8_type utf8_encode(input logic [31:0] v);
      utf8_type    r;
      logic [35:0] w;
      w       = {4'h0, v};
      r.count = '0;
      r.bytes = '0;
      if (v < 32'h0000_0080) begin
         r.count    = XEU_COUNT_BITS'(1);
         r.bytes[0] = v[7:0];
      end else if (v < 32'h0000_0800) begin
         r.count    = XEU_COUNT_BITS'(2);
         r.bytes[0] = 8'hC0 | {2'b00, w[11:6]};
         r.bytes[1] = {2'b10, w[5:0]};
      end else if (v < 32'h0001_0000) begin
         r.count    = XEU_COUNT_BITS'(3);
         r.bytes[0] = 8'hE0 | {2'b00, w[17:12]};
         r.bytes[1] = {2'b10, w[11:6]};
         r.bytes[2] = {2'b10, w[5:0]};
      end else if (v < 32'h0020_0000) begin
         r.count    = XEU_COUNT_BITS'(4);
         r.bytes[0] = 8'hF0 | {2'b00, w[23:18]};
         r.bytes[1] = {2'b10, w[17:12]};
         r.bytes[2] = {2'b10, w[11:6]};
         r.bytes[3] = {2'b10, w[5:0]};
      end else if (v < 32'h0400_0000) begin
         r.count    = XEU_COUNT_BITS'(5);
         r.bytes[0] = 8'hF8 | {2'b00, w[29:24]};
         r.bytes[1] = {2'b10, w[23:18]};
         r.bytes[2] = {2'b10, w[17:12]};
         r.bytes[3] = {2'b10, w[11:6]};
         r.bytes[4] = {2'b10, w[5:0]};
      end else if (v < 32'h8000_0000) begin
         r.count    = XEU_COUNT_BITS'(6);
         r.bytes[0] = 8'hFC | {2'b00, w[35:30]};
         r.bytes[1] = {2'b10, w[29:24]};
         r.bytes[2] = {2'b10, w[23:18]};
         r.bytes[3] = {2'b10, w[17:12]};
         r.bytes[4] = {2'b10, w[11:6]};
         r.bytes[5] = {2'b10, w[5:0]};
      end
      return r;
   endfunction

endpackage

// ----- src/xml_entity_unescape.sv -----
// an accepted item passes the input register and then the result register
// throughput: one item per cycle while each item yields at most one result and rsp_ready is high
// an item with k results holds the result register until all k are sent (one result port)
// items that yield no result pass through the input register without waiting
// reset (synchronous, active high) empties both registers and returns to plain text
// ---------------------------------------------------------------------------
// xml_entity_unescape
// streaming xml entity decoder: named and numeric references to bytes / utf-8
// ---------------------------------------------------------------------------
module xml_entity_unescape #(
   parameter int VALUE_BITS = xeu_pkg::XEU_VALUE_BITS   // 21 .. 32
) (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_in,
   // result item channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_has_byte,
   output logic        rsp_run_last,
   output logic        rsp_end_of_text
);

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   xeu_pkg::burst_type res;
   logic               step;
   logic               burst_free;
   logic               take;

   // the held item moves on when it has nothing to send or the result
   // register is empty or draining its final result in this cycle
   assign step      = in_valid_ff && ((res.count == '0) || burst_free);
   assign req_ready = !in_valid_ff || step;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last_in;
      end
   end

   // parse state and decode of the held item
   xeu_parse #(
      .VALUE_BITS (VALUE_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .last_in (in_last_ff),
      .res     (res)
   );

   // result register, one result per accepted transfer
   xeu_burst u_burst (
      .clock           (clock),
      .reset           (reset),
      .load            (step && (res.count != '0)),
      .res             (res),
      .free            (burst_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_end_of_text (rsp_end_of_text)
   );

endmodule

// ----- src/xeu_parse.sv -----
// ---------------------------------------------------------------------------
// xeu_parse
// parse state and one-step decode of a held byte into its group of results
// ---------------------------------------------------------------------------
module xeu_parse #(
   parameter int VALUE_BITS = xeu_pkg::XEU_VALUE_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          in_byte,
   input  logic                last_in,
   output xeu_pkg::burst_type  res
);

   localparam int NC = xeu_pkg::XEU_NAME_COUNT;
   localparam int PM = xeu_pkg::XEU_PREFIX_MAX;

   xeu_pkg::mode_type         mode_ff, mode_in, mode_step;
   logic [7:0]                pb_ff [PM];
   logic [7:0]                pb_in [PM];
   logic [2:0]                pcount_ff, pcount_in, pcount_step;
   logic [NC-1:0]             cand_ff, cand_in;
   logic [VALUE_BITS-1:0]     code_ff, code_in, code_step;
   logic                      hex_ff, hex_in, hex_step;

   logic                      is_lt, is_amp, is_hash, is_x, is_semi;
   logic [NC-1:0]             hit;
   logic                      done_any, cont_ok, amp_hash, amp_mismatch, plain_path;
   logic [7:0]                done_char;
   logic [4:0]                digit;
   logic [VALUE_BITS-1:0]     digit_ext, code_acc;
   xeu_pkg::mode_type         plain_next;
   logic                      store, emit1, emit_code, accumulate;
   logic [7:0]                single;
   logic [2:0]                rn;
   xeu_pkg::utf8_type         enc;

   assign is_lt   = (in_byte == xeu_pkg::CHAR_LT);
   assign is_amp  = (in_byte == xeu_pkg::CHAR_AMP);
   assign is_hash = (in_byte == xeu_pkg::CHAR_HASH);
   assign is_x    = (in_byte == xeu_pkg::CHAR_LOWER_X) || (in_byte == xeu_pkg::CHAR_UPPER_X);
   assign is_semi = (in_byte == xeu_pkg::CHAR_SEMI);

   // name match against the candidates still alive
   always_comb begin
      hit       = '0;
      done_any  = 1'b0;
      done_char = 8'h00;
      for (int k = 0; k < NC; k++) begin
         if (cand_ff[k] && (xeu_pkg::NAME_LEN[k] > pcount_ff) &&
             (xeu_pkg::NAME_TEXT[k][pcount_ff] == in_byte)) begin
            hit[k] = 1'b1;
            if (xeu_pkg::NAME_LEN[k] == 3'(pcount_ff + 3'd1)) begin
               done_any  = 1'b1;
               done_char = xeu_pkg::NAME_CHAR[k];
            end
         end
      end
   end

   assign amp_hash     = (mode_ff == xeu_pkg::MODE_AMP) && (pcount_ff == 3'd0) && is_hash;
   assign cont_ok      = (|hit) && (pcount_ff < 3'(PM));
   assign amp_mismatch = (mode_ff == xeu_pkg::MODE_AMP) && !amp_hash && !done_any && !cont_ok;
   assign plain_path   = (mode_ff == xeu_pkg::MODE_PLAIN) || amp_mismatch;
   assign store        = (mode_ff == xeu_pkg::MODE_AMP) && !amp_hash && !done_any && cont_ok;

   assign plain_next = is_lt  ? xeu_pkg::MODE_STOP :
                       is_amp ? xeu_pkg::MODE_AMP   : xeu_pkg::MODE_PLAIN;

   // next parse mode
   always_comb begin
      unique case (mode_ff)
         xeu_pkg::MODE_PLAIN: mode_step = plain_next;
         xeu_pkg::MODE_AMP: begin
            if (amp_hash)      mode_step = xeu_pkg::MODE_NUM_START;
            else if (done_any) mode_step = xeu_pkg::MODE_PLAIN;
            else if (cont_ok)  mode_step = xeu_pkg::MODE_AMP;
            else               mode_step = plain_next;
         end
         xeu_pkg::MODE_NUM_START:
            mode_step = (is_semi && !is_x) ? xeu_pkg::MODE_PLAIN : xeu_pkg::MODE_NUM_DIGITS;
         xeu_pkg::MODE_NUM_DIGITS:
            mode_step = is_semi ? xeu_pkg::MODE_PLAIN : xeu_pkg::MODE_NUM_DIGITS;
         xeu_pkg::MODE_STOP: mode_step = xeu_pkg::MODE_STOP;
         default:            mode_step = xeu_pkg::MODE_PLAIN;
      endcase
      if (!step)        mode_in = mode_ff;
      else if (last_in) mode_in = xeu_pkg::MODE_PLAIN;
      else              mode_in = mode_step;
   end

   // numeric accumulate, times ten or sixteen with wrap
   assign digit      = xeu_pkg::digit_of(in_byte);
   assign digit_ext  = digit[4] ? '1 : VALUE_BITS'(digit[3:0]);
   assign code_acc   = hex_ff ? ((code_ff << 4) + digit_ext)
                              : ((code_ff << 3) + (code_ff << 1) + digit_ext);
   assign accumulate = ((mode_ff == xeu_pkg::MODE_NUM_START) && !is_x && !is_semi) ||
                       ((mode_ff == xeu_pkg::MODE_NUM_DIGITS) && !is_semi);

   // datapath next values and result group
   always_comb begin
      code_step = code_ff;
      hex_step  = hex_ff;
      if (amp_hash) begin
         code_step = '0;
         hex_step  = 1'b0;
      end else if (accumulate) begin
         code_step = code_acc;
      end else if ((mode_ff == xeu_pkg::MODE_NUM_START) && is_x) begin
         hex_step = 1'b1;
      end

      pcount_step = store ? 3'(pcount_ff + 3'd1) : 3'd0;
      cand_in     = store ? hit : '1;
      for (int i = 0; i < PM; i++) begin
         pb_in[i] = pb_ff[i];
      end
      if (store) pb_in[pcount_ff[1:0]] = in_byte;

      emit1  = (plain_path && !is_lt && !is_amp) || done_any;
      single = done_any ? done_char : in_byte;

      if (amp_mismatch)
         rn = pcount_ff;
      else if (last_in && (mode_step == xeu_pkg::MODE_AMP))
         rn = pcount_step;
      else
         rn = 3'd0;

      emit_code = (((mode_ff == xeu_pkg::MODE_NUM_START) && !is_x) ||
                   (mode_ff == xeu_pkg::MODE_NUM_DIGITS)) && is_semi;
      if (last_in && ((mode_step == xeu_pkg::MODE_NUM_START) ||
                      (mode_step == xeu_pkg::MODE_NUM_DIGITS)))
         emit_code = 1'b1;

      enc = xeu_pkg::utf8_encode(32'(code_step));

      res          = '0;
      res.has_byte = 1'b1;
      res.eot      = last_in;
      if (emit_code) begin
         res.count = enc.count;
         res.bytes = enc.bytes;
      end else begin
         for (int i = 0; i < PM; i++) begin
            if (3'(i) < rn) res.bytes[i] = pb_in[i];
         end
         if (emit1) res.bytes[rn] = single;
         res.count = xeu_pkg::XEU_COUNT_BITS'(rn) + xeu_pkg::XEU_COUNT_BITS'(emit1);
      end
      // bare end marker when the final byte gives nothing
      if (last_in && (res.count == '0)) begin
         res.count    = xeu_pkg::XEU_COUNT_BITS'(1);
         res.has_byte = 1'b0;
         res.bytes    = '0;
      end

      if (!step) begin
         pcount_in = pcount_ff;
         code_in   = code_ff;
         hex_in    = hex_ff;
      end else if (last_in) begin
         pcount_in = 3'd0;
         code_in   = '0;
         hex_in    = 1'b0;
      end else begin
         pcount_in = pcount_step;
         code_in   = code_step;
         hex_in    = hex_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= xeu_pkg::MODE_PLAIN;
         pcount_ff <= 3'd0;
         code_ff   <= '0;
         hex_ff    <= 1'b0;
         cand_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         pcount_ff <= pcount_in;
         code_ff   <= code_in;
         hex_ff    <= hex_in;
         if (step) cand_ff <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && store) pb_ff <= pb_in;
   end

endmodule

// ----- src/xeu_burst.sv -----
// ---------------------------------------------------------------------------
// xeu_burst
// result register holding one item's group, shifted out one result per cycle while rsp_ready is high
// ---------------------------------------------------------------------------
module xeu_burst (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  xeu_pkg::burst_type  res,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_has_byte,
   output logic                rsp_run_last,
   output logic                rsp_end_of_text
);

   localparam int CB = xeu_pkg::XEU_COUNT_BITS;

   logic                                    valid_ff;
   logic [CB-1:0]                           left_ff;
   logic [xeu_pkg::XEU_MAX_RESULTS-1:0][7:0] bytes_ff;
   logic                                    has_ff, eot_ff;
   logic                                    pop, at_last;

   assign at_last = (left_ff == CB'(1));
   assign pop     = valid_ff && rsp_ready;
   assign free    = !valid_ff || (rsp_ready && at_last);

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = bytes_ff[0];
   assign rsp_has_byte    = has_ff;
   assign rsp_run_last    = at_last;
   assign rsp_end_of_text = eot_ff && at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         left_ff  <= res.count;
      end else if (pop) begin
         valid_ff <= !at_last;
         left_ff  <= CB'(left_ff - CB'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= res.bytes;
         has_ff   <= res.has_byte;
         eot_ff   <= res.eot;
      end else if (pop) begin
         bytes_ff <= {8'h00, bytes_ff[xeu_pkg::XEU_MAX_RESULTS-1:1]};
      end
   end

endmodule

// ----- src/xeu_checker.sv -----
// ---------------------------------------------------------------------------
// xeu_checker
// port-level checks of the result channel, bound to the top level
// ---------------------------------------------------------------------------
`include "xml_entity_unescape_defines.svh"

module xeu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_has_byte,
   input logic        rsp_run_last,
   input logic        rsp_end_of_text
);

   // a stalled result holds
   `XEU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_has_byte) && $stable(rsp_run_last) && $stable(rsp_end_of_text), "stalled result changed")

   // a bare marker only closes the text
   `XEU_ASSERT_NOW(a_bare_marker, clock, reset, rsp_valid && !rsp_has_byte, rsp_end_of_text && rsp_run_last && (rsp_out_byte == 8'h00), "bare marker not a closing zero result")

   // end of text is always the last result of its item
   `XEU_ASSERT_NOW(a_end_is_last, clock, reset, rsp_valid && rsp_end_of_text, rsp_run_last, "end of text without run last")

   // after reset nothing is pending and input is open
   `XEU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready, "not empty after reset")

endmodule

bind xml_entity_unescape xeu_checker u_xeu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_has_byte    (rsp_has_byte),
   .rsp_run_last    (rsp_run_last),
   .rsp_end_of_text (rsp_end_of_text)
);

// ----- tb/unescape_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// unescape_checker
// watches both item channels of the entity decoder, predicts the decoded
// bytes of every accepted input item and compares them, field by field, with
// the result items in order of arrival
// ---------------------------------------------------------------------------
module unescape_checker #(
   parameter int VALUE_BITS = xeu_pkg::XEU_VALUE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_in,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_has_byte,
   input  logic       rsp_run_last,
   input  logic       rsp_end_of_text,
   output int         pending,
   output int         errors
);
   import xeu_pkg::*;

   localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;

   typedef struct packed {
      logic [7:0] data;
      logic       has_data;
      logic       run_end;
      logic       text_end;
   } decoded_type;

   // decoder state as predicted
   mode_type    mode;
   logic [7:0]  held [XEU_PREFIX_MAX];
   int          held_n;
   logic [31:0] code_acc;
   logic        hex_mode;

   decoded_type burst[$];          // results of the byte being decoded
   decoded_type decoded_q[$];      // results still owed by the block
   decoded_type want;
   int          mismatch_count = 0;

   task automatic report(input string what, input logic [7:0] got,
                         input logic [7:0] exp_val);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("%0t mismatch: %s got %02h expected %02h", $realtime, what, got, exp_val);
   endtask

   task automatic clear_state();
      mode = MODE_PLAIN;
      foreach (held[i]) held[i] = 8'h00;
      held_n   = 0;
      code_acc = '0;
      hex_mode = 1'b0;
   endtask

   // append one result to the group of the current byte
   task automatic add_result(input decoded_type r);
      burst = {burst, r};
   endtask

   task automatic emit(input logic [7:0] b);
      decoded_type r;
      r.data     = b;
      r.has_data = 1'b1;
      r.run_end  = 1'b0;
      r.text_end = 1'b0;
      if (burst.size() < XEU_MAX_RESULTS) add_result(r);
   endtask

   // original utf-8: one to six bytes, nothing at 2^31 and above
   task automatic emit_code();
      int          n;
      logic [7:0]  lead;
      logic [31:0] part;
      n    = 0;
      lead = 8'h00;
      if (code_acc < 32'h80) begin
         emit(code_acc[7:0]);
      end else begin
         if (code_acc < 32'h800) begin
            n = 2; lead = 8'hC0;
         end else if (code_acc < 32'h1_0000) begin
            n = 3; lead = 8'hE0;
         end else if (code_acc < 32'h20_0000) begin
            n = 4; lead = 8'hF0;
         end else if (code_acc < 32'h400_0000) begin
            n = 5; lead = 8'hF8;
         end else if (code_acc < 32'h8000_0000) begin
            n = 6; lead = 8'hFC;
         end
         if (n > 0) begin
            part = code_acc >> (6 * (n - 1));
            emit(lead | part[7:0]);
            for (int i = n - 2; i >= 0; i--) begin
               part = code_acc >> (6 * i);
               emit(8'h80 | {2'b00, part[5:0]});
            end
         end
      end
   endtask

   task automatic replay_held();
      for (int i = 0; i < held_n && i < XEU_PREFIX_MAX; i++) emit(held[i]);
      held_n = 0;
   endtask

   task automatic take_text_byte(input logic [7:0] c);
      if (c == CHAR_LT) begin
         mode = MODE_STOP;
      end else if (c == CHAR_AMP) begin
         mode   = MODE_AMP;
         held_n = 0;
      end else begin
         emit(c);
      end
   endtask

   // non-digits count as minus one, sum wraps
   task automatic fold_digit(input logic [7:0] c);
      logic [63:0] d;
      logic [63:0] w;
      if (c >= "0" && c <= "9")      d = 64'(c - "0");
      else if (c >= "a" && c <= "f") d = 64'(c - "a" + 10);
      else if (c >= "A" && c <= "F") d = 64'(c - "A" + 10);
      else                           d = 64'h0000_0000_FFFF_FFFF;
      w        = ({32'd0, code_acc} * (hex_mode ? 64'd16 : 64'd10) + d) & VALUE_MASK;
      code_acc = w[31:0];
   endtask

   task automatic decode_byte(input logic [7:0] c, input logic is_last);
      int          n;
      bit          partial;
      bit          matched;
      bit          agree;
      decoded_type r;
      burst.delete();
      case (mode)
         MODE_PLAIN: take_text_byte(c);
         MODE_AMP: begin
            n = (held_n > XEU_PREFIX_MAX) ? XEU_PREFIX_MAX : held_n;
            if (n == 0 && c == CHAR_HASH) begin
               mode     = MODE_NUM_START;
               code_acc = '0;
               hex_mode = 1'b0;
            end else begin
               partial = 1'b0;
               matched = 1'b0;
               for (int k = 0; k < XEU_NAME_COUNT; k++) begin
                  if (!matched && int'(NAME_LEN[k]) > n) begin
                     agree = 1'b1;
                     for (int j = 0; j < n; j++)
                        if (held[j] != NAME_TEXT[k][j]) agree = 1'b0;
                     if (agree && NAME_TEXT[k][n] == c) begin
                        if (n + 1 == int'(NAME_LEN[k])) begin
                           emit(NAME_CHAR[k]);
                           mode    = MODE_PLAIN;
                           held_n  = 0;
                           matched = 1'b1;
                        end else begin
                           partial = 1'b1;
                        end
                     end
                  end
               end
               if (!matched) begin
                  if (partial && n < XEU_PREFIX_MAX) begin
                     held[n] = c;
                     held_n  = n + 1;
                  end else begin
                     mode   = MODE_PLAIN;
                     held_n = n;
                     replay_held();
                     take_text_byte(c);
                  end
               end
            end
         end
         MODE_NUM_START: begin
            if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
               hex_mode = 1'b1;
               mode     = MODE_NUM_DIGITS;
            end else if (c == CHAR_SEMI) begin
               emit_code();
               mode = MODE_PLAIN;
            end else begin
               fold_digit(c);
               mode = MODE_NUM_DIGITS;
            end
         end
         MODE_NUM_DIGITS: begin
            if (c == CHAR_SEMI) begin
               emit_code();
               mode = MODE_PLAIN;
            end else begin
               fold_digit(c);
            end
         end
         default: mode = MODE_STOP;
      endcase

      if (is_last) begin
         if (mode == MODE_AMP)
            replay_held();
         else if (mode == MODE_NUM_START || mode == MODE_NUM_DIGITS)
            emit_code();
         clear_state();
         if (burst.size() == 0) begin
            r = '0;
            add_result(r);
         end
         r          = burst.pop_back();
         r.text_end = 1'b1;
         add_result(r);
      end
      if (burst.size() > 0) begin
         r         = burst.pop_back();
         r.run_end = 1'b1;
         add_result(r);
      end
      decoded_q = {decoded_q, burst};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         decoded_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               report("result with nothing expected, out_byte", rsp_out_byte, 8'h00);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_out_byte != want.data)
                  report("out_byte", rsp_out_byte, want.data);
               if (rsp_has_byte != want.has_data)
                  report("has_byte", {7'd0, rsp_has_byte}, {7'd0, want.has_data});
               if (rsp_run_last != want.run_end)
                  report("run_last", {7'd0, rsp_run_last}, {7'd0, want.run_end});
               if (rsp_end_of_text != want.text_end)
                  report("end_of_text", {7'd0, rsp_end_of_text}, {7'd0, want.text_end});
            end
         end
         if (req_valid && req_ready) decode_byte(req_in_byte, req_last_in);
      end
      pending <= decoded_q.size();
      errors  <= mismatch_count;
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// drives escaped texts into the entity decoder: a few hand-picked texts for
// the corner cases, then random texts made mostly of valid named and numeric
// references mixed with plain bytes and broken references, with random gaps
// on the input side and random stalls on the result side
// ---------------------------------------------------------------------------
module testbench;
   import xeu_pkg::*;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // input item channel
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_last_in = 1'b0;

   // result item channel
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_run_last;
   logic       rsp_end_of_text;

   // from the checker
   int pending;
   int errors;

   // stimulus bookkeeping
   logic [7:0] text_q[$];      // bytes of the text being built
   int         sent = 0;       // input items accepted so far
   bit         quiet_tail = 1'b0;
   int         stall_left = 0;
   int         calm_left  = 0;

   always #2 clock = ~clock;

   xml_entity_unescape uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_last_in     (req_last_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_end_of_text (rsp_end_of_text)
   );

   unescape_checker rsp_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_last_in     (req_last_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_end_of_text (rsp_end_of_text),
      .pending         (pending),
      .errors          (errors)
   );

   // result side: random stall bursts, with calm stretches between
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left <= calm_left - 1;
         rsp_ready <= 1'b1;
      end else if (!reset && !quiet_tail && $urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            calm_left <= $urandom_range(10, 40);
            rsp_ready <= 1'b1;
         end else begin
            stall_left <= $urandom_range(0, 5);
            rsp_ready  <= 1'b0;
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one input item; valid stays up into the next call unless a gap is taken
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_last_in <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // whole text, last flag on its final byte
   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   // append one byte to the text being built
   task automatic add_text_byte(input logic [7:0] b);
      text_q = {text_q, b};
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) add_text_byte(s[i]);
   endtask

   // sender holds off until every owed result has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // named reference, sometimes cut short and ended by a stray byte
   task automatic add_name();
      int k;
      int cut;
      k = $urandom_range(0, XEU_NAME_COUNT - 1);
      add_text_byte(CHAR_AMP);
      if ($urandom_range(0, 4) != 0) begin
         for (int j = 0; j < int'(NAME_LEN[k]); j++) add_text_byte(NAME_TEXT[k][j]);
      end else begin
         cut = $urandom_range(0, int'(NAME_LEN[k]) - 1);
         for (int j = 0; j < cut; j++) add_text_byte(NAME_TEXT[k][j]);
         if ($urandom_range(0, 1) == 0)
            add_text_byte(8'($urandom_range(0, 255)));
         else
            add_text_byte(8'($urandom_range(8'h61, 8'h7A)));
      end
   endtask

   // numeric reference, decimal or hex, values spread over all utf-8 lengths
   task automatic add_number();
      logic [31:0] v;
      logic [7:0]  d;
      logic [7:0]  digs[$];
      bit          hex;
      hex = ($urandom_range(0, 1) == 1);
      v   = $urandom >> $urandom_range(0, 31);
      add_text_byte(CHAR_AMP);
      add_text_byte(CHAR_HASH);
      if (hex) add_text_byte($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
      // now and then an empty reference
      if ($urandom_range(0, 9) != 0) begin
         do begin
            d = 8'(hex ? v % 16 : v % 10);
            if (d < 10)
               digs.push_front(8'("0" + d));
            else
               digs.push_front(8'(($urandom_range(0, 1) ? "a" : "A") + d - 8'd10));
            v = hex ? v / 16 : v / 10;
         end while (v != 0);
         // extra leading digit so that the sum may wrap
         if ($urandom_range(0, 7) == 0) digs.push_front(8'("1" + 8'($urandom_range(0, 8))));
         // stray random byte, folded in as minus one unless it is a digit
         if ($urandom_range(0, 9) == 0) digs = {digs, 8'($urandom_range(0, 255))};
         foreach (digs[i]) add_text_byte(digs[i]);
      end
      // rarely left open, then the following bytes fold into it
      if ($urandom_range(0, 11) != 0) add_text_byte(CHAR_SEMI);
   endtask

   // random text of a few tokens
   task automatic build_text();
      int sel;
      repeat ($urandom_range(1, 8)) begin
         sel = $urandom_range(0, 19);
         if (sel < 8)
            repeat ($urandom_range(1, 4)) add_text_byte(8'($urandom_range(0, 255)));
         else if (sel < 14)
            add_name();
         else if (sel < 19)
            add_number();
         else
            add_text_byte($urandom_range(0, 1) ? CHAR_LT : CHAR_AMP);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // byte extremes, then a name left open at the end of the text
      add_text_byte(8'h00);
      add_text_byte(8'hFF);
      push_str("&qu");
      send_text();
      // empty hex reference flushed by the end of the text
      push_str("&#x");
      send_text();
      // name broken by a stop byte, held letters come back first
      push_str("&lt<");
      send_text();
      // non-digit turns the code huge: no bytes, bare end marker
      push_str("&#-9");
      send_text();
      // largest code that still encodes, six utf-8 bytes
      push_str("&#x7FFFFFFF;");
      send_text();

      wait_drained();

      // random texts with idling on both sides
      while (sent < 370) begin
         build_text();
         send_text();
         if (sent >= 200 && sent < 215) wait_drained();
      end

      // last stretch at full rate
      quiet_tail = 1'b1;
      while (sent < 450) begin
         build_text();
         send_text();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
